// ===== design/arpc_pkg.sv =====
// Shared types and constants for the ARP cache and responder.
// Used by arpc_cell and arp_cache_responder; no dependencies of its own.
package arpc_pkg;

  // Default cache depth and fixed field widths
  localparam int CacheDepth = 16;
  localparam int IpW        = 32;
  localparam int MacW       = 48;
  localparam int HalfW      = 16;
  localparam int IdxOutW    = 4;
  localparam int StatusW    = 2;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 48;

  // Stream widths: input tdata 176 bits, output tdata 132 bits padded to 136
  localparam int InDataW    = 176;
  localparam int OutDataW   = 136;
  localparam int OutUserW   = 3;

  // ARP protocol codes
  localparam logic [HalfW-1:0] ArpHwEthernet = 16'd1;
  localparam logic [HalfW-1:0] ArpOpRequest  = 16'd1;
  localparam logic [HalfW-1:0] ArpOpReply    = 16'd2;

  // Item kinds on the input tuser
  localparam logic ModePacket = 1'b0;
  localparam logic ModeLookup = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StatusOk     = 2'd0;
  localparam logic [StatusW-1:0] StatusBadHw  = 2'd1;
  localparam logic [StatusW-1:0] StatusMiss   = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHostIp  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgHostMac = 4'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_COMMIT
  } state_e;

  // Controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic capture;  // latch this cell's first-match flag
    logic shift;    // take the neighbor's pair (insert at the front)
    logic write;    // overwrite the MAC of the matching cell
  } cell_ctl_t;

endpackage

// ===== design/arpc_cell.sv =====
// One cache slot of the ARP cache: an IP/MAC pair, its compare and its
// place in the lowest-match chain. Depends on arpc_pkg.
module arpc_cell
  import arpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic            valid_i,     // slot lies below the fill count
  input  logic [IpW-1:0]  key_i,       // address being searched
  input  logic            seen_i,      // a lower slot already matched
  output logic            seen_o,
  input  logic [IpW-1:0]  prev_ip_i,   // neighbor pair for a shift
  input  logic [MacW-1:0] prev_mac_i,
  input  logic [MacW-1:0] new_mac_i,   // MAC for an in-place update
  output logic [IpW-1:0]  ip_o,
  output logic [MacW-1:0] mac_o,
  output logic            first_o      // this slot is the lowest match
);

  logic [IpW-1:0]  ip_q;
  logic [MacW-1:0] mac_q;
  logic            first_q, first_d;
  logic            hit;

  // Compare and pass the match along the chain
  assign hit     = valid_i && (ip_q == key_i);
  assign seen_o  = seen_i | hit;
  assign first_d = hit & ~seen_i;

  // Hold the lowest-match flag until the commit cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
    end else if (ctl_i.capture) begin
      first_q <= first_d;
    end
  end

  // Shift in from the neighbor, or update the MAC in place
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      ip_q  <= prev_ip_i;
      mac_q <= prev_mac_i;
    end else if (ctl_i.write && first_q) begin
      mac_q <= new_mac_i;
    end
  end

  assign ip_o    = ip_q;
  assign mac_o   = mac_q;
  assign first_o = first_q;

endmodule

// ===== design/arp_cache_responder.sv =====
// ARP cache and responder top level: item register, sequencer, row of
// arpc_cell slots and output register. Depends on arpc_pkg and arpc_cell.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | tuser mode, tdata packet/query
//  m_axis   | out       | m_axis_tvalid/tready      | tuser status/reply flag, tdata
//  cfg      | in        | cfg_valid_i/cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Each item passes a compare step, in which every cell compares its IP and the
// lowest match is resolved along the cell chain, and a commit step, which
// commits the update and loads the result. The next item is taken in the commit cycle.
// Reset clears the fill count and control state; no clearing pass is needed.
// A stalled output holds the commit step; the output register lets the next
// item start while the previous result waits.
module arp_cache_responder
  import arpc_pkg::*;
#(
  parameter int CACHE_DEPTH = CacheDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input item stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] hw_space, [31:16] opcode, [63:32] sender_ip, [111:64] sender_mac,
  // [143:112] target_ip, [175:144] query_ip
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] mode
  input  logic                s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] entry_index, [51:4] entry_mac, [99:52] reply_target_mac,
  // [131:100] reply_target_ip, [135:132] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] status, [2] reply_valid
  output logic [OutUserW-1:0] m_axis_tuser,
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CntW = $clog2(CACHE_DEPTH + 1);

  // Configuration registers
  logic [IpW-1:0]  host_ip_q;
  logic [MacW-1:0] host_mac_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_ip_q  <= '0;
      host_mac_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHostIp:  host_ip_q  <= cfg_data_i[IpW-1:0];
        CfgHostMac: host_mac_q <= cfg_data_i[MacW-1:0];
        default:    ;
      endcase
    end
  end

  // Sequencer state and handshake
  state_e    state_q, state_d;
  logic      accept, commit_go;
  logic      out_valid_q;
  cell_ctl_t ctl;

  // Item register
  logic             mode_q;
  logic [HalfW-1:0] hw_space_q, opcode_q;
  logic [IpW-1:0]   sender_ip_q, target_ip_q, query_ip_q;
  logic [MacW-1:0]  sender_mac_q;
  logic             pkt_ok;

  assign commit_go     = (state_q == ST_COMMIT) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || commit_go;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pkt_ok        = (mode_q == ModePacket) && (hw_space_q == ArpHwEthernet);

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= s_axis_tuser;
      hw_space_q   <= s_axis_tdata[15:0];
      opcode_q     <= s_axis_tdata[31:16];
      sender_ip_q  <= s_axis_tdata[63:32];
      sender_mac_q <= s_axis_tdata[111:64];
      target_ip_q  <= s_axis_tdata[143:112];
      query_ip_q   <= s_axis_tdata[175:144];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_CMP;
      ST_CMP:    state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (commit_go) state_d = accept ? ST_CMP : ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Cell row
  logic [CACHE_DEPTH-1:0] valid_vec, first_vec;
  logic [CACHE_DEPTH:0]   seen;
  logic [IpW-1:0]         cell_ip  [CACHE_DEPTH];
  logic [MacW-1:0]        cell_mac [CACHE_DEPTH];
  logic [IpW-1:0]         key;
  logic [CntW-1:0]        count_q;
  logic                   any_hit;

  assign key     = (mode_q == ModeLookup) ? query_ip_q : sender_ip_q;
  assign seen[0] = 1'b0;
  assign any_hit = |first_vec;

  // Drive the cell controls
  always_comb begin
    ctl.capture = (state_q == ST_CMP);
    ctl.shift   = commit_go && pkt_ok && !any_hit;
    ctl.write   = commit_go && pkt_ok && any_hit;
  end

  for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
    logic [IpW-1:0]  prev_ip;
    logic [MacW-1:0] prev_mac;

    assign valid_vec[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign prev_ip  = sender_ip_q;
      assign prev_mac = sender_mac_q;
    end else begin : g_body
      assign prev_ip  = cell_ip[g-1];
      assign prev_mac = cell_mac[g-1];
    end

    arpc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .valid_i    (valid_vec[g]),
      .key_i      (key),
      .seen_i     (seen[g]),
      .seen_o     (seen[g+1]),
      .prev_ip_i  (prev_ip),
      .prev_mac_i (prev_mac),
      .new_mac_i  (sender_mac_q),
      .ip_o       (cell_ip[g]),
      .mac_o      (cell_mac[g]),
      .first_o    (first_vec[g])
    );
  end

  // Advance the fill count on an insert, saturating at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl.shift && (count_q < CntW'(CACHE_DEPTH))) begin
      count_q <= count_q + CntW'(1);
    end
  end

  // Select the matching slot's position and MAC
  logic [IdxOutW-1:0] hit_idx;
  logic [MacW-1:0]    hit_mac;

  always_comb begin
    hit_idx = '0;
    hit_mac = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (first_vec[i]) begin
        hit_idx = hit_idx | IdxOutW'(i);
        hit_mac = hit_mac | cell_mac[i];
      end
    end
  end

  // Build the result
  logic [StatusW-1:0] status_d;
  logic [IdxOutW-1:0] idx_d;
  logic [MacW-1:0]    mac_d, rmac_d;
  logic [IpW-1:0]     rip_d;
  logic               rvalid_d;

  always_comb begin
    status_d = StatusOk;
    idx_d    = '0;
    mac_d    = '0;
    rvalid_d = 1'b0;
    rmac_d   = '0;
    rip_d    = '0;
    if (mode_q == ModeLookup) begin
      if (any_hit) begin
        idx_d = hit_idx;
        mac_d = hit_mac;
      end else begin
        status_d = StatusMiss;
      end
    end else if (hw_space_q != ArpHwEthernet) begin
      status_d = StatusBadHw;
    end else begin
      idx_d = any_hit ? hit_idx : '0;
      mac_d = sender_mac_q;
      if ((target_ip_q == host_ip_q) && (opcode_q == ArpOpRequest)) begin
        rvalid_d = 1'b1;
        rmac_d   = sender_mac_q;
        rip_d    = sender_ip_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      out_data_q <= {4'd0, rip_d, rmac_d, mac_d, idx_d};
      out_user_q <= {rvalid_d, status_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Checks
  a_shift_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.shift && ctl.write))
    else $error("shift and in-place write in the same cycle");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_vec))
    else $error("more than one cell flagged as lowest match");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CACHE_DEPTH))
    else $error("fill count beyond cache depth");

  a_count_on_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(ctl.shift))
    else $error("fill count moved without an insert");

endmodule

// ===== dv/arp_cache_responder_test.sv =====
// Self-checking testbench for arp_cache_responder: streams ARP packets and
// lookups, predicts each result with its own cache model and compares them.
// Depends on arpc_pkg and the arp_cache_responder RTL.
module arp_cache_responder_test;
  import arpc_pkg::*;

  localparam int Depth      = CacheDepth;
  localparam int PoolSize   = 24;
  localparam int RandPerSet = 500;
  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 400;

  // One input item, by field
  typedef struct packed {
    logic             mode;
    logic [HalfW-1:0] hw_space;
    logic [HalfW-1:0] opcode;
    logic [IpW-1:0]   sender_ip;
    logic [MacW-1:0]  sender_mac;
    logic [IpW-1:0]   target_ip;
    logic [IpW-1:0]   query_ip;
  } arp_item_t;

  // One result, by field
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdxOutW-1:0] entry_index;
    logic [MacW-1:0]    entry_mac;
    logic               reply_valid;
    logic [MacW-1:0]    reply_target_mac;
    logic [IpW-1:0]     reply_target_ip;
  } arp_answer_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [15:0] hw_space, [31:16] opcode, [63:32] sender_ip, [111:64] sender_mac,
  // [143:112] target_ip, [175:144] query_ip
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // [0] mode
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [3:0] entry_index, [51:4] entry_mac, [99:52] reply_target_mac,
  // [131:100] reply_target_ip, [135:132] zero
  logic [OutDataW-1:0] m_axis_tdata;
  // [1:0] status, [2] reply_valid
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  arp_cache_responder #(
    .CACHE_DEPTH(Depth)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // Cache model and station registers
  logic [IpW-1:0]  cache_ip_m  [Depth];
  logic [MacW-1:0] cache_mac_m [Depth];
  int              fill_m;
  logic [IpW-1:0]  station_ip;
  logic [MacW-1:0] station_mac;
  logic [IpW-1:0]  ip_pool [PoolSize];

  arp_item_t   arp_items_q[$];
  arp_answer_t cache_answers_q[$];
  arp_item_t   item_in_flight;

  int gap_left;
  int burst_left;
  int items_sent;
  int results_seen;
  int mismatches;
  int cycle_count;
  int hold_left;
  bit hold_done;
  int rx_cycle;

  // Run statistics
  int n_inserts, n_updates, n_replies, n_lookup_hits, n_misses, n_bad_hw;

  // Lowest valid position holding ip, or -1
  function automatic int cache_position(logic [IpW-1:0] ip);
    for (int i = 0; i < fill_m; i++) begin
      if (cache_ip_m[i] == ip) return i;
    end
    return -1;
  endfunction

  // Apply one item to the cache model and work out its result
  function automatic arp_answer_t resolve_arp_item(arp_item_t it);
    arp_answer_t a;
    int pos;
    a = '0;
    a.status = StatusOk;
    if (it.mode == ModeLookup) begin
      pos = cache_position(it.query_ip);
      if (pos >= 0) begin
        a.entry_index = pos[IdxOutW-1:0];
        a.entry_mac   = cache_mac_m[pos];
        n_lookup_hits++;
      end else begin
        a.status = StatusMiss;
        n_misses++;
      end
    end else if (it.hw_space != ArpHwEthernet) begin
      a.status = StatusBadHw;
      n_bad_hw++;
    end else begin
      pos = cache_position(it.sender_ip);
      if (pos >= 0) begin
        cache_mac_m[pos] = it.sender_mac;
        a.entry_index    = pos[IdxOutW-1:0];
        n_updates++;
      end else begin
        // shift in at the front, oldest falls off
        for (int k = Depth - 1; k > 0; k--) begin
          cache_ip_m[k]  = cache_ip_m[k-1];
          cache_mac_m[k] = cache_mac_m[k-1];
        end
        cache_ip_m[0]  = it.sender_ip;
        cache_mac_m[0] = it.sender_mac;
        if (fill_m < Depth) fill_m++;
        n_inserts++;
      end
      a.entry_mac = it.sender_mac;
      if (it.target_ip == station_ip && it.opcode == ArpOpRequest) begin
        a.reply_valid      = 1'b1;
        a.reply_target_mac = it.sender_mac;
        a.reply_target_ip  = it.sender_ip;
        n_replies++;
      end
    end
    return a;
  endfunction

  function automatic logic [MacW-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MacW-1:0];
  endfunction

  function automatic logic [IpW-1:0] pick_ip();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return ip_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  function automatic arp_item_t make_packet(logic [HalfW-1:0] hw, logic [HalfW-1:0] op,
                                            logic [IpW-1:0] sip, logic [MacW-1:0] smac,
                                            logic [IpW-1:0] tip);
    arp_item_t it;
    it.mode       = ModePacket;
    it.hw_space   = hw;
    it.opcode     = op;
    it.sender_ip  = sip;
    it.sender_mac = smac;
    it.target_ip  = tip;
    it.query_ip   = $urandom;
    return it;
  endfunction

  function automatic arp_item_t make_lookup(logic [IpW-1:0] qip);
    arp_item_t it;
    it.mode       = ModeLookup;
    it.hw_space   = HalfW'($urandom);
    it.opcode     = HalfW'($urandom);
    it.sender_ip  = $urandom;
    it.sender_mac = rand_mac();
    it.target_ip  = $urandom;
    it.query_ip   = qip;
    return it;
  endfunction

  // Mostly well-formed packets and lookups on a small address pool, some noise
  function automatic arp_item_t random_item();
    int r;
    logic [HalfW-1:0] op;
    logic [IpW-1:0] tip;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      case ($urandom_range(0, 6))
        0:       op = ArpOpReply;
        1:       op = HalfW'($urandom);
        default: op = ArpOpRequest;
      endcase
      tip = ($urandom_range(0, 1) == 1) ? station_ip : pick_ip();
      return make_packet(ArpHwEthernet, op, pick_ip(), rand_mac(), tip);
    end else if (r < 88) begin
      return make_lookup(pick_ip());
    end
    return make_packet(HalfW'($urandom), HalfW'($urandom), $urandom, rand_mac(),
                       ($urandom_range(0, 1) == 1) ? station_ip : $urandom);
  endfunction

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Global cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Input driver: hold a stalled item, else advance through bursts and gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        cache_answers_q.push_back(resolve_arp_item(item_in_flight));
        items_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (arp_items_q.size() > 0) begin
          item_in_flight = arp_items_q.pop_front();
          s_axis_tdata  <= {item_in_flight.query_ip, item_in_flight.target_ip,
                            item_in_flight.sender_mac, item_in_flight.sender_ip,
                            item_in_flight.opcode, item_in_flight.hw_space};
          s_axis_tuser  <= item_in_flight.mode;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result ready: one long hold-off, otherwise a rotating stall pattern
  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 400) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_cycle[7:6])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_axis_tready <= ($urandom_range(0, 9) != 0);
        default: m_axis_tready <= (rx_cycle[1:0] == 2'd0);
      endcase
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    arp_answer_t got;
    arp_answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status           = m_axis_tuser[1:0];
      got.reply_valid      = m_axis_tuser[2];
      got.entry_index      = m_axis_tdata[3:0];
      got.entry_mac        = m_axis_tdata[51:4];
      got.reply_target_mac = m_axis_tdata[99:52];
      got.reply_target_ip  = m_axis_tdata[131:100];
      results_seen++;
      if (cache_answers_q.size() == 0) begin
        $error("result %0d arrived with nothing predicted", results_seen);
        mismatches++;
      end else begin
        want = cache_answers_q.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0h, got %0h", want.status, got.status);
          mismatches++;
        end
        if (got.entry_index != want.entry_index) begin
          $error("entry_index: expected %0h, got %0h", want.entry_index, got.entry_index);
          mismatches++;
        end
        if (got.entry_mac != want.entry_mac) begin
          $error("entry_mac: expected %0h, got %0h", want.entry_mac, got.entry_mac);
          mismatches++;
        end
        if (got.reply_valid != want.reply_valid) begin
          $error("reply_valid: expected %0h, got %0h", want.reply_valid, got.reply_valid);
          mismatches++;
        end
        if (got.reply_target_mac != want.reply_target_mac) begin
          $error("reply_target_mac: expected %0h, got %0h",
                 want.reply_target_mac, got.reply_target_mac);
          mismatches++;
        end
        if (got.reply_target_ip != want.reply_target_ip) begin
          $error("reply_target_ip: expected %0h, got %0h",
                 want.reply_target_ip, got.reply_target_ip);
          mismatches++;
        end
      end
    end
  end

  // Write one configuration register and mirror it in the model
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgHostIp) station_ip = data[IpW-1:0];
    else if (idx == CfgHostMac) station_mac = data[MacW-1:0];
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain();
    while (arp_items_q.size() != 0 || s_axis_tvalid || cache_answers_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    rst_ni      <= 1'b0;
    fill_m      = 0;
    station_ip  = '0;
    station_mac = '0;
    for (int i = 0; i < PoolSize; i++) ip_pool[i] = $urandom;
    for (int i = 0; i < Depth; i++) begin
      cache_ip_m[i]  = '0;
      cache_mac_m[i] = '0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CfgHostIp, {16'h0, ip_pool[0]});
    write_reg(CfgHostMac, rand_mac());

    // Directed: empty lookup, foreign hardware spaces, edge addresses, opcodes
    arp_items_q.push_back(make_lookup(32'h0));
    arp_items_q.push_back(make_packet(16'h0000, ArpOpRequest, 32'h0, 48'h0, ip_pool[0]));
    arp_items_q.push_back(make_packet(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                      48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    arp_items_q.push_back(make_packet(16'h0002, ArpOpRequest, ip_pool[1], rand_mac(),
                                      ip_pool[0]));
    arp_items_q.push_back(make_packet(ArpHwEthernet, ArpOpRequest, 32'h0, 48'h0,
                                      ip_pool[0]));
    arp_items_q.push_back(make_packet(ArpHwEthernet, ArpOpRequest, 32'hFFFF_FFFF,
                                      48'hFFFF_FFFF_FFFF, ip_pool[0]));
    arp_items_q.push_back(make_packet(ArpHwEthernet, ArpOpReply, 32'hFFFF_FFFF, rand_mac(),
                                      ip_pool[0]));
    arp_items_q.push_back(make_packet(ArpHwEthernet, 16'h0000, 32'h0, 48'hFFFF_FFFF_FFFF,
                                      ip_pool[0]));
    arp_items_q.push_back(make_packet(ArpHwEthernet, 16'hFFFF, ip_pool[1], rand_mac(),
                                      ip_pool[0]));
    arp_items_q.push_back(make_packet(ArpHwEthernet, ArpOpRequest, ip_pool[2], rand_mac(),
                                      ~ip_pool[0]));
    arp_items_q.push_back(make_lookup(32'h0));
    arp_items_q.push_back(make_lookup(32'hFFFF_FFFF));
    // fill the cache past its depth so the oldest entry falls off
    for (int k = 3; k <= 15; k++) begin
      arp_items_q.push_back(make_packet(ArpHwEthernet, ArpOpRequest, ip_pool[k],
                                        rand_mac(), ip_pool[k]));
    end
    arp_items_q.push_back(make_lookup(32'h0));
    drain();

    // Random sets under three station settings, the extremes among them
    for (int set_no = 0; set_no < 3; set_no++) begin
      case (set_no)
        0: begin
          write_reg(CfgHostIp, '0);
          write_reg(CfgHostMac, '0);
        end
        1: begin
          write_reg(CfgHostIp, {16'hFFFF, 32'hFFFF_FFFF});
          write_reg(CfgHostMac, 48'hFFFF_FFFF_FFFF);
        end
        default: begin
          write_reg(CfgHostIp, {HalfW'($urandom_range(0, 65535)),
                                ip_pool[$urandom_range(0, 7)]});
          write_reg(CfgHostMac, rand_mac());
        end
      endcase
      for (int n = 0; n < RandPerSet; n++) arp_items_q.push_back(random_item());
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d items: %0d inserts, %0d MAC updates, %0d replies, %0d bad hw",
             items_sent, n_inserts, n_updates, n_replies, n_bad_hw);
    $display("Lookups: %0d hits, %0d misses; %0d results checked, %0d mismatches",
             n_lookup_hits, n_misses, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
